/* hw/rtl/gpr_pkg.sv */
// shared types, codes and helpers for the gpio port register block
`timescale 1ns / 1ps

package gpr_pkg;

  // number of pins in a full port
  localparam int unsigned GprMaxPins   = 16;
  localparam int unsigned GprPinCount  = 16;
  // lock key sits just above the pin mask in the lock register
  localparam int unsigned GprLockKeyBit = 16;

  // bus request operations
  typedef enum logic [1:0] {
    OpRead   = 2'd0,
    OpWrite  = 2'd1,
    OpSample = 2'd2
  } op_e;

  // register map
  typedef enum logic [3:0] {
    RegMode     = 4'd0,
    RegOtype    = 4'd1,
    RegSpeed    = 4'd2,
    RegPull     = 4'd3,
    RegIndata   = 4'd4,
    RegOutdata  = 4'd5,
    RegSetReset = 4'd6,
    RegLock     = 4'd7,
    RegAfLow    = 4'd8,
    RegAfHigh   = 4'd9
  } reg_idx_e;

  // one request as held in the input register
  typedef struct packed {
    logic [1:0]  op;
    logic [3:0]  idx;
    logic [31:0] wdata;
    logic [15:0] levels;
  } gpr_req_t;

  // one result as held in the output register
  typedef struct packed {
    logic [31:0] rdata;
    logic [15:0] drive;
    logic [15:0] oe;
    logic        lock_active;
  } gpr_res_t;

  // widen a pin mask to two bits per pin
  function automatic logic [31:0] spread2(input logic [15:0] m);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < 16; i++) begin
      r[2*i +: 2] = {2{m[i]}};
    end
    return r;
  endfunction

  // widen eight pins of a mask to four bits per pin
  function automatic logic [31:0] spread4(input logic [7:0] m);
    logic [31:0] r;
    r = '0;
    for (int i = 0; i < 8; i++) begin
      r[4*i +: 4] = {4{m[i]}};
    end
    return r;
  endfunction

endpackage

/* hw/rtl/gpr_regfile.sv */
// port configuration and data registers with lock sequence and result logic
`timescale 1ns / 1ps

module gpr_regfile import gpr_pkg::*; #(
  parameter int unsigned PinCount = GprPinCount
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     req_valid_i,
  input  gpr_req_t req_i,
  output gpr_res_t res_o
);

  typedef enum logic [1:0] {
    LkIdle  = 2'd0,
    LkKey1  = 2'd1,
    LkKey0  = 2'd2,
    LkArmed = 2'd3
  } lock_step_e;

  logic [31:0] mode_q, mode_d, speed_q, speed_d, pull_q, pull_d;
  logic [31:0] af_lo_q, af_lo_d, af_hi_q, af_hi_d;
  logic [15:0] otype_q, otype_d, odr_q, odr_d, idr_q, idr_d;
  logic [15:0] lock_mask_q, lock_mask_d;
  lock_step_e  lock_step_q, lock_step_d;
  logic        lock_key_q, lock_key_d;

  logic [15:0] pm, open, wmask, set_bits, clr_bits;
  logic [31:0] w2, rdata;
  logic        key;

  // pins that exist in this port
  always_comb begin
    for (int i = 0; i < GprMaxPins; i++) begin
      pm[i] = (i < PinCount);
    end
  end

  // pins whose configuration may still change
  assign open     = lock_key_q ? (pm & ~lock_mask_q) : pm;
  assign w2       = spread2(open);
  assign wmask    = req_i.wdata[15:0] & pm;
  assign key      = req_i.wdata[GprLockKeyBit];
  assign set_bits = req_i.wdata[15:0] & pm;
  assign clr_bits = req_i.wdata[31:16] & pm;

  // next state and read data for one request
  always_comb begin
    mode_d      = mode_q;
    otype_d     = otype_q;
    speed_d     = speed_q;
    pull_d      = pull_q;
    af_lo_d     = af_lo_q;
    af_hi_d     = af_hi_q;
    odr_d       = odr_q;
    idr_d       = idr_q;
    lock_mask_d = lock_mask_q;
    lock_step_d = lock_step_q;
    lock_key_d  = lock_key_q;
    rdata       = '0;
    if (req_valid_i) begin
      if (req_i.op == OpRead) begin
        case (req_i.idx)
          RegMode:    rdata = mode_q;
          RegOtype:   rdata = {16'b0, otype_q};
          RegSpeed:   rdata = speed_q;
          RegPull:    rdata = pull_q;
          RegIndata:  rdata = {16'b0, idr_q};
          RegOutdata: rdata = {16'b0, odr_q};
          RegLock: begin
            // reading the lock register completes an armed sequence
            if (!lock_key_q) begin
              if (lock_step_q == LkArmed) begin
                lock_key_d = 1'b1;
              end
              lock_step_d = LkIdle;
            end
            rdata = {15'b0, lock_key_d, lock_mask_q};
          end
          RegAfLow:   rdata = af_lo_q;
          RegAfHigh:  rdata = af_hi_q;
          default:    rdata = '0;
        endcase
      end else if (req_i.op == OpWrite) begin
        case (req_i.idx)
          RegMode:    mode_d  = (mode_q & ~w2) | (req_i.wdata & w2);
          RegOtype:   otype_d = (otype_q & ~open) | (req_i.wdata[15:0] & open);
          RegSpeed:   speed_d = (speed_q & ~w2) | (req_i.wdata & w2);
          RegPull:    pull_d  = (pull_q & ~w2) | (req_i.wdata & w2);
          RegOutdata: odr_d   = req_i.wdata[15:0] & pm;
          // set wins over reset
          RegSetReset: odr_d  = ((odr_q & ~clr_bits) | set_bits) & pm;
          RegLock: begin
            if (!lock_key_q) begin
              if (lock_step_q == LkKey1 && !key && wmask == lock_mask_q) begin
                lock_step_d = LkKey0;
              end else if (lock_step_q == LkKey0 && key && wmask == lock_mask_q) begin
                lock_step_d = LkArmed;
              end else begin
                lock_step_d = key ? LkKey1 : LkIdle;
              end
              lock_mask_d = wmask;
            end
          end
          RegAfLow: begin
            af_lo_d = (af_lo_q & ~spread4(open[7:0])) | (req_i.wdata & spread4(open[7:0]));
          end
          RegAfHigh: begin
            af_hi_d = (af_hi_q & ~spread4(open[15:8])) | (req_i.wdata & spread4(open[15:8]));
          end
          default: ;
        endcase
      end else if (req_i.op == OpSample) begin
        idr_d = req_i.levels & pm;
      end
    end
  end

  // result fields reflect the state after this request
  always_comb begin
    res_o.rdata       = rdata;
    res_o.drive       = odr_d;
    res_o.lock_active = lock_key_d;
    for (int i = 0; i < GprMaxPins; i++) begin
      // output or alternate function mode drives the pin
      res_o.oe[i] = (mode_d[2*i] ^ mode_d[2*i+1]) & pm[i];
    end
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= '0;
      otype_q     <= '0;
      speed_q     <= '0;
      pull_q      <= '0;
      af_lo_q     <= '0;
      af_hi_q     <= '0;
      odr_q       <= '0;
      idr_q       <= '0;
      lock_mask_q <= '0;
      lock_step_q <= LkIdle;
      lock_key_q  <= 1'b0;
    end else begin
      mode_q      <= mode_d;
      otype_q     <= otype_d;
      speed_q     <= speed_d;
      pull_q      <= pull_d;
      af_lo_q     <= af_lo_d;
      af_hi_q     <= af_hi_d;
      odr_q       <= odr_d;
      idr_q       <= idr_d;
      lock_mask_q <= lock_mask_d;
      lock_step_q <= lock_step_d;
      lock_key_q  <= lock_key_d;
    end
  end

endmodule

/* hw/rtl/gpio_port_register_block_unit.sv */
// Top level of the gpio port register block: each request is a register read,
// a register write or a sample of the pin levels, and gives one result. A new
// request is taken every cycle unless the pipeline stalls; a request is held in
// the input register, updates the port registers as it moves to the result
// register, and its result is offered from there. Both registers stall together
// when the result is not taken. The lock key sequence freezes the configuration
// of the masked pins until reset.
`timescale 1ns / 1ps

module gpio_port_register_block_unit import gpr_pkg::*; #(
  parameter int unsigned PinCount = GprPinCount
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  operation_i,
  input  logic [3:0]  reg_index_i,
  input  logic [31:0] write_data_i,
  input  logic [15:0] pin_levels_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] read_data_o,
  output logic [15:0] pin_drive_o,
  output logic [15:0] pin_output_enable_o,
  output logic        lock_active_o
);

  logic     in_vld_q, out_vld_q, adv, take;
  gpr_req_t req_q;
  gpr_res_t res, res_q;

  // pipeline control
  assign adv        = in_vld_q & (~out_vld_q | out_ready_i);
  assign in_ready_o = ~in_vld_q | adv;
  assign take       = in_valid_i & in_ready_o;

  // register file and result logic
  gpr_regfile #(
    .PinCount(PinCount)
  ) u_regfile (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(adv),
    .req_i      (req_q),
    .res_o      (res)
  );

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_vld_q <= in_valid_i;
      end
      if (adv) begin
        out_vld_q <= 1'b1;
      end else if (out_ready_i) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (take) begin
      req_q <= '{op: operation_i, idx: reg_index_i, wdata: write_data_i,
                 levels: pin_levels_i};
    end
    if (adv) begin
      res_q <= res;
    end
  end

  assign out_valid_o         = out_vld_q;
  assign read_data_o         = res_q.rdata;
  assign pin_drive_o         = res_q.drive;
  assign pin_output_enable_o = res_q.oe;
  assign lock_active_o       = res_q.lock_active;

endmodule
